FILE: rtl/mwm_pkg.sv
// Package for the maze wall map with pose: grid size, field widths,
// operation codes and heading codes. No dependencies.
package mwm_pkg;

   localparam int GRID_SIDE = 16;
   localparam int POS_W     = $clog2(GRID_SIDE);        // pose coordinate width
   localparam int COORD_W   = 6;                        // signed request coordinate width
   localparam int HROW_W    = $clog2(GRID_SIDE + 1);    // horizontal wall row index
   localparam int VCOL_W    = $clog2(GRID_SIDE + 1);    // vertical wall column index

   typedef enum logic [2:0] {
      FN_CLEAR        = 3'd0,
      FN_UPDATE_WALLS = 3'd1,
      FN_SET_POSE     = 3'd2,
      FN_ADVANCE      = 3'd3,
      FN_TURN_LEFT    = 3'd4,
      FN_TURN_RIGHT   = 3'd5,
      FN_QUERY_WALLS  = 3'd6,
      FN_QUERY_KNOWN  = 3'd7
   } func_type;

   typedef logic [1:0] heading_type;

   localparam heading_type HD_NORTH = 2'd0;
   localparam heading_type HD_EAST  = 2'd1;
   localparam heading_type HD_SOUTH = 2'd2;
   localparam heading_type HD_WEST  = 2'd3;

   // relative turns on the compass, modulo four
   localparam heading_type TURN_LEFT_STEP  = 2'd3;
   localparam heading_type TURN_RIGHT_STEP = 2'd1;

endpackage

FILE: rtl/maze_wall_map_with_pose_core.sv
// Maze wall map with robot pose: wall and visited bit arrays in flops, pose registers.
// Depends on mwm_pkg.
//
// Usage:
//   Request channel (req_valid / req_stall): one item carries an operation code
//   (clear, update walls, set pose, advance, turn left, turn right, query walls,
//   query known), a signed cell coordinate, a heading and three sensed wall bits.
//   Response channel (rsp_valid / rsp_stall): one item per request with the
//   query answers, the advance flag and the pose after the operation.
//   Pipeline: request register, then response register. Throughput: one item
//   per cycle while no waiting response is held by rsp_stall; the whole
//   operation is decoded, applied to the map and answered combinationally
//   between the request register and the response register, so each item
//   sees the map left by the one before it.
//   Reset: the map holds only the outer boundary walls, no cell is known and
//   the pose is cell (0,0) facing north; both registers are emptied.
//   Stall: while rsp_stall holds a waiting response, the request register keeps
//   its item and req_stall rises; nothing is lost or repeated.
module maze_wall_map_with_pose_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mwm_pkg::func_type                  req_func,
   input  logic signed [mwm_pkg::COORD_W-1:0] req_cell_x,
   input  logic signed [mwm_pkg::COORD_W-1:0] req_cell_y,
   input  mwm_pkg::heading_type               req_heading_in,
   input  logic                               req_seen_front,
   input  logic                               req_seen_left,
   input  logic                               req_seen_right,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_wall_front,
   output logic                               rsp_wall_left,
   output logic                               rsp_wall_right,
   output logic                               rsp_cell_known,
   output logic                               rsp_moved,
   output logic [mwm_pkg::POS_W-1:0]          rsp_pose_x,
   output logic [mwm_pkg::POS_W-1:0]          rsp_pose_y,
   output mwm_pkg::heading_type               rsp_pose_heading
);
   import mwm_pkg::*;

   // request register
   logic                      in_valid_ff;
   func_type                  in_func_ff;
   logic signed [COORD_W-1:0] in_x_ff;
   logic signed [COORD_W-1:0] in_y_ff;
   heading_type               in_hd_ff;
   logic                      in_sf_ff, in_sl_ff, in_sr_ff;

   // map and pose
   logic [GRID_SIDE:0]   vwall_ff [GRID_SIDE];
   logic [GRID_SIDE:0]   vwall_in [GRID_SIDE];
   logic [GRID_SIDE-1:0] hwall_ff [GRID_SIDE+1];
   logic [GRID_SIDE-1:0] hwall_in [GRID_SIDE+1];
   logic [GRID_SIDE-1:0] known_ff [GRID_SIDE];
   logic [GRID_SIDE-1:0] known_in [GRID_SIDE];
   logic [POS_W-1:0]     pose_x_ff, pose_x_in;
   logic [POS_W-1:0]     pose_y_ff, pose_y_in;
   heading_type          pose_hd_ff, pose_hd_in;

   // response register
   logic rsp_valid_ff;
   logic wf_ff, wl_ff, wr_ff, kn_ff, mv_ff;
   logic wf_in, wl_in, wr_in, kn_in, mv_in;

   logic advance;

   logic              x_ok, y_ok;
   logic [POS_W-1:0]  qx, qy;
   logic [HROW_W-1:0] qy_north;
   logic [VCOL_W-1:0] qx_east;
   logic [3:0]        q_side;
   logic [HROW_W-1:0] py_north;
   logic [VCOL_W-1:0] px_east;
   logic [3:0]        set_side;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   // query coordinates: in range only when non-negative and below the grid side
   assign x_ok = !in_x_ff[COORD_W-1] && ({1'b0, in_x_ff} < (COORD_W+1)'(GRID_SIDE));
   assign y_ok = !in_y_ff[COORD_W-1] && ({1'b0, in_y_ff} < (COORD_W+1)'(GRID_SIDE));
   assign qx       = in_x_ff[POS_W-1:0];
   assign qy       = in_y_ff[POS_W-1:0];
   assign qy_north = HROW_W'(qy) + HROW_W'(1);
   assign qx_east  = VCOL_W'(qx) + VCOL_W'(1);

   // compass sides of the queried cell, indexed by heading code
   assign q_side[HD_NORTH] = hwall_ff[qy_north][qx];
   assign q_side[HD_EAST]  = vwall_ff[qy][qx_east];
   assign q_side[HD_SOUTH] = hwall_ff[qy][qx];
   assign q_side[HD_WEST]  = vwall_ff[qy][qx];

   assign py_north = HROW_W'(pose_y_ff) + HROW_W'(1);
   assign px_east  = VCOL_W'(pose_x_ff) + VCOL_W'(1);

   // sensed walls relative to the heading, turned into compass sides
   always_comb begin
      for (int s = 0; s < 4; s++) begin
         set_side[s] = (in_sf_ff && (pose_hd_ff == heading_type'(s)))
                    || (in_sl_ff && (heading_type'(pose_hd_ff + TURN_LEFT_STEP)
                                     == heading_type'(s)))
                    || (in_sr_ff && (heading_type'(pose_hd_ff + TURN_RIGHT_STEP)
                                     == heading_type'(s)));
      end
   end

   always_comb begin
      vwall_in   = vwall_ff;
      hwall_in   = hwall_ff;
      known_in   = known_ff;
      pose_x_in  = pose_x_ff;
      pose_y_in  = pose_y_ff;
      pose_hd_in = pose_hd_ff;
      wf_in = 1'b0;
      wl_in = 1'b0;
      wr_in = 1'b0;
      kn_in = 1'b0;
      mv_in = 1'b0;
      unique case (in_func_ff)
         FN_CLEAR: begin
            for (int r = 0; r < GRID_SIDE; r++) begin
               vwall_in[r] = '0;
               vwall_in[r][0] = 1'b1;
               vwall_in[r][GRID_SIDE] = 1'b1;
               known_in[r] = '0;
            end
            for (int r = 1; r < GRID_SIDE; r++) begin
               hwall_in[r] = '0;
            end
            hwall_in[0]         = '1;
            hwall_in[GRID_SIDE] = '1;
            pose_x_in  = '0;
            pose_y_in  = '0;
            pose_hd_in = HD_NORTH;
         end
         FN_UPDATE_WALLS: begin
            known_in[pose_y_ff][pose_x_ff] = 1'b1;
            if (set_side[HD_NORTH]) hwall_in[py_north][pose_x_ff] = 1'b1;
            if (set_side[HD_EAST])  vwall_in[pose_y_ff][px_east] = 1'b1;
            if (set_side[HD_SOUTH]) hwall_in[pose_y_ff][pose_x_ff] = 1'b1;
            if (set_side[HD_WEST])  vwall_in[pose_y_ff][pose_x_ff] = 1'b1;
         end
         FN_SET_POSE: begin
            if (x_ok) pose_x_in = qx;
            if (y_ok) pose_y_in = qy;
            pose_hd_in = in_hd_ff;
         end
         FN_ADVANCE: begin
            unique case (pose_hd_ff)
               HD_NORTH: begin
                  if (pose_y_ff != POS_W'(GRID_SIDE - 1)) begin
                     pose_y_in = pose_y_ff + POS_W'(1);
                     mv_in = 1'b1;
                  end
               end
               HD_EAST: begin
                  if (pose_x_ff != POS_W'(GRID_SIDE - 1)) begin
                     pose_x_in = pose_x_ff + POS_W'(1);
                     mv_in = 1'b1;
                  end
               end
               HD_SOUTH: begin
                  if (pose_y_ff != '0) begin
                     pose_y_in = pose_y_ff - POS_W'(1);
                     mv_in = 1'b1;
                  end
               end
               default: begin
                  if (pose_x_ff != '0) begin
                     pose_x_in = pose_x_ff - POS_W'(1);
                     mv_in = 1'b1;
                  end
               end
            endcase
         end
         FN_TURN_LEFT:  pose_hd_in = pose_hd_ff + TURN_LEFT_STEP;
         FN_TURN_RIGHT: pose_hd_in = pose_hd_ff + TURN_RIGHT_STEP;
         FN_QUERY_WALLS: begin
            if (x_ok && y_ok) begin
               wf_in = q_side[in_hd_ff];
               wl_in = q_side[heading_type'(in_hd_ff + TURN_LEFT_STEP)];
               wr_in = q_side[heading_type'(in_hd_ff + TURN_RIGHT_STEP)];
            end else begin
               wf_in = 1'b1;
               wl_in = 1'b1;
               wr_in = 1'b1;
            end
         end
         default: begin
            if (x_ok && y_ok) kn_in = known_ff[qy][qx];
         end
      endcase
   end

   // request register: load whenever it is empty or drains this cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_func_ff <= req_func;
         in_x_ff    <= req_cell_x;
         in_y_ff    <= req_cell_y;
         in_hd_ff   <= req_heading_in;
         in_sf_ff   <= req_seen_front;
         in_sl_ff   <= req_seen_left;
         in_sr_ff   <= req_seen_right;
      end
   end

   // map and pose: boundary walls only after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < GRID_SIDE; r++) begin
            vwall_ff[r] <= {1'b1, {(GRID_SIDE-1){1'b0}}, 1'b1};
            known_ff[r] <= '0;
         end
         for (int r = 1; r < GRID_SIDE; r++) begin
            hwall_ff[r] <= '0;
         end
         hwall_ff[0]         <= '1;
         hwall_ff[GRID_SIDE] <= '1;
         pose_x_ff  <= '0;
         pose_y_ff  <= '0;
         pose_hd_ff <= HD_NORTH;
      end else if (advance) begin
         vwall_ff   <= vwall_in;
         hwall_ff   <= hwall_in;
         known_ff   <= known_in;
         pose_x_ff  <= pose_x_in;
         pose_y_ff  <= pose_y_in;
         pose_hd_ff <= pose_hd_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         wf_ff <= wf_in;
         wl_ff <= wl_in;
         wr_ff <= wr_in;
         kn_ff <= kn_in;
         mv_ff <= mv_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_wall_front   = wf_ff;
   assign rsp_wall_left    = wl_ff;
   assign rsp_wall_right   = wr_ff;
   assign rsp_cell_known   = kn_ff;
   assign rsp_moved        = mv_ff;
   assign rsp_pose_x       = pose_x_ff;
   assign rsp_pose_y       = pose_y_ff;
   assign rsp_pose_heading = pose_hd_ff;

   // one outer boundary wall on each side of the maze is never lost
   assert property (@(posedge clock) disable iff (reset)
      vwall_ff[0][0] && vwall_ff[GRID_SIDE-1][GRID_SIDE] && hwall_ff[0][0]
      && hwall_ff[GRID_SIDE][GRID_SIDE-1])
      else $error("boundary wall cleared");

   // only an advance can report a move
   assert property (@(posedge clock) disable iff (reset)
      advance && (in_func_ff != FN_ADVANCE) |=> !rsp_moved)
      else $error("moved set by an operation other than advance");

   // a clear leaves the pose at the origin facing north and the origin unknown
   assert property (@(posedge clock) disable iff (reset)
      advance && (in_func_ff == FN_CLEAR) |=>
         (pose_x_ff == '0) && (pose_y_ff == '0) && (pose_hd_ff == HD_NORTH)
         && !known_ff[0][0])
      else $error("clear did not restore the map and pose");

   // a wall query outside the maze answers walled on every side
   assert property (@(posedge clock) disable iff (reset)
      advance && (in_func_ff == FN_QUERY_WALLS) && !(x_ok && y_ok) |=>
         rsp_valid && rsp_wall_front && rsp_wall_left && rsp_wall_right)
      else $error("outside query not walled");

   // the request side stalls only while it holds an item
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled without a blocked item");

endmodule

FILE: tb/sv/tb_top.sv
// Testbench for maze_wall_map_with_pose_core: predicts wall, visited and pose answers per item
// and checks every response in order, under random idling and back-pressure.
// Depends on mwm_pkg and the core RTL.
module tb_top;
   import mwm_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 10;

   typedef struct {
      func_type          op;
      logic signed [5:0] cx;
      logic signed [5:0] cy;
      heading_type       hd;
      logic              sf;
      logic              sl;
      logic              sr;
   } maze_cmd_type;

   typedef struct {
      logic        wf;
      logic        wl;
      logic        wr;
      logic        kn;
      logic        mv;
      logic [3:0]  px;
      logic [3:0]  py;
      heading_type ph;
   } maze_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid      = 1'b0;
   logic              req_stall;
   func_type          req_func       = FN_CLEAR;
   logic signed [5:0] req_cell_x     = '0;
   logic signed [5:0] req_cell_y     = '0;
   heading_type       req_heading_in = HD_NORTH;
   logic              req_seen_front = 1'b0;
   logic              req_seen_left  = 1'b0;
   logic              req_seen_right = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall      = 1'b0;
   logic              rsp_wall_front;
   logic              rsp_wall_left;
   logic              rsp_wall_right;
   logic              rsp_cell_known;
   logic              rsp_moved;
   logic [3:0]        rsp_pose_x;
   logic [3:0]        rsp_pose_y;
   heading_type       rsp_pose_heading;

   // predicted map and pose
   logic        vert_wall  [GRID_SIDE][GRID_SIDE+1];
   logic        horiz_wall [GRID_SIDE+1][GRID_SIDE];
   logic        visited    [GRID_SIDE][GRID_SIDE];
   logic [3:0]  mouse_x;
   logic [3:0]  mouse_y;
   heading_type mouse_hd;

   maze_rsp_type expected_answers [$];
   int        error_count  = 0;
   int        cycle_count  = 0;
   int        src_idle_pct = 0;
   int        snk_idle_pct = 0;
   int        hold_request = 0;
   int        hold_left    = 0;

   maze_wall_map_with_pose_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .req_heading_in   (req_heading_in),
      .req_seen_front   (req_seen_front),
      .req_seen_left    (req_seen_left),
      .req_seen_right   (req_seen_right),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_wall_front   (rsp_wall_front),
      .rsp_wall_left    (rsp_wall_left),
      .rsp_wall_right   (rsp_wall_right),
      .rsp_cell_known   (rsp_cell_known),
      .rsp_moved        (rsp_moved),
      .rsp_pose_x       (rsp_pose_x),
      .rsp_pose_y       (rsp_pose_y),
      .rsp_pose_heading (rsp_pose_heading)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_maze();
      for (int y = 0; y < GRID_SIDE; y++) begin
         for (int x = 0; x <= GRID_SIDE; x++) begin
            vert_wall[y][x] = (x == 0) || (x == GRID_SIDE);
         end
      end
      for (int y = 0; y <= GRID_SIDE; y++) begin
         for (int x = 0; x < GRID_SIDE; x++) begin
            horiz_wall[y][x] = (y == 0) || (y == GRID_SIDE);
         end
      end
      for (int y = 0; y < GRID_SIDE; y++) begin
         for (int x = 0; x < GRID_SIDE; x++) begin
            visited[y][x] = 1'b0;
         end
      end
      mouse_x  = '0;
      mouse_y  = '0;
      mouse_hd = HD_NORTH;
   endfunction

   // a north wall of one cell is the south wall of the next, likewise east and west
   function automatic logic wall_on_side(int x, int y, heading_type side);
      case (side)
         HD_NORTH: return horiz_wall[y+1][x];
         HD_EAST:  return vert_wall[y][x+1];
         HD_SOUTH: return horiz_wall[y][x];
         default:  return vert_wall[y][x];
      endcase
   endfunction

   function automatic void raise_wall(int x, int y, heading_type side);
      case (side)
         HD_NORTH: horiz_wall[y+1][x] = 1'b1;
         HD_EAST:  vert_wall[y][x+1]  = 1'b1;
         HD_SOUTH: horiz_wall[y][x]   = 1'b1;
         default:  vert_wall[y][x]    = 1'b1;
      endcase
   endfunction

   function automatic maze_rsp_type apply_maze_op(maze_cmd_type c);
      maze_rsp_type r;
      int        qx;
      int        qy;
      logic      on_grid;
      heading_type left_hd;
      heading_type right_hd;
      qx       = c.cx;
      qy       = c.cy;
      on_grid  = (qx >= 0) && (qx < GRID_SIDE) && (qy >= 0) && (qy < GRID_SIDE);
      r.wf     = 1'b0;
      r.wl     = 1'b0;
      r.wr     = 1'b0;
      r.kn     = 1'b0;
      r.mv     = 1'b0;
      case (c.op)
         FN_CLEAR: begin
            clear_maze();
         end
         FN_UPDATE_WALLS: begin
            left_hd  = heading_type'(mouse_hd + TURN_LEFT_STEP);
            right_hd = heading_type'(mouse_hd + TURN_RIGHT_STEP);
            visited[mouse_y][mouse_x] = 1'b1;
            if (c.sf) raise_wall(mouse_x, mouse_y, mouse_hd);
            if (c.sl) raise_wall(mouse_x, mouse_y, left_hd);
            if (c.sr) raise_wall(mouse_x, mouse_y, right_hd);
         end
         FN_SET_POSE: begin
            // each coordinate is taken only when in range
            if (qx >= 0 && qx < GRID_SIDE) mouse_x = qx[3:0];
            if (qy >= 0 && qy < GRID_SIDE) mouse_y = qy[3:0];
            mouse_hd = c.hd;
         end
         FN_ADVANCE: begin
            case (mouse_hd)
               HD_NORTH: if (mouse_y < GRID_SIDE - 1) begin mouse_y++; r.mv = 1'b1; end
               HD_EAST:  if (mouse_x < GRID_SIDE - 1) begin mouse_x++; r.mv = 1'b1; end
               HD_SOUTH: if (mouse_y > 0) begin mouse_y--; r.mv = 1'b1; end
               default:  if (mouse_x > 0) begin mouse_x--; r.mv = 1'b1; end
            endcase
         end
         FN_TURN_LEFT: begin
            mouse_hd = heading_type'(mouse_hd + TURN_LEFT_STEP);
         end
         FN_TURN_RIGHT: begin
            mouse_hd = heading_type'(mouse_hd + TURN_RIGHT_STEP);
         end
         FN_QUERY_WALLS: begin
            if (on_grid) begin
               r.wf = wall_on_side(qx, qy, c.hd);
               r.wl = wall_on_side(qx, qy, heading_type'(c.hd + TURN_LEFT_STEP));
               r.wr = wall_on_side(qx, qy, heading_type'(c.hd + TURN_RIGHT_STEP));
            end else begin
               r.wf = 1'b1;
               r.wl = 1'b1;
               r.wr = 1'b1;
            end
         end
         default: begin
            if (on_grid) r.kn = visited[qy][qx];
         end
      endcase
      r.px = mouse_x;
      r.py = mouse_y;
      r.ph = mouse_hd;
      return r;
   endfunction

   // ---------------------------------------------------------------- sender

   function automatic maze_cmd_type make_cmd(func_type op, int x, int y, heading_type hd,
                                             logic sf, logic sl, logic sr);
      maze_cmd_type c;
      c.op = op;
      c.cx = 6'(x);
      c.cy = 6'(y);
      c.hd = hd;
      c.sf = sf;
      c.sl = sl;
      c.sr = sr;
      return c;
   endfunction

   task automatic send_cmd(input maze_cmd_type c);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= c.op;
      req_cell_x     <= c.cx;
      req_cell_y     <= c.cy;
      req_heading_in <= c.hd;
      req_seen_front <= c.sf;
      req_seen_left  <= c.sl;
      req_seen_right <= c.sr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_answers.push_back(apply_maze_op(c));
   endtask

   function automatic logic signed [5:0] pick_coord(int pose_coord);
      int r;
      int d;
      r = $urandom_range(0, 99);
      d = $urandom_range(0, 2);
      if (r < 50) return 6'(pose_coord + d - 1);   // next to the mouse, may fall off
      if (r < 90) return 6'($urandom_range(0, GRID_SIDE - 1));
      return 6'($urandom);
   endfunction

   function automatic maze_cmd_type random_cmd();
      maze_cmd_type c;
      int        pick;
      c.op = func_type'($urandom_range(0, 7));
      c.cx = 6'($urandom);
      c.cy = 6'($urandom);
      c.hd = heading_type'($urandom_range(0, 3));
      c.sf = 1'($urandom);
      c.sl = 1'($urandom);
      c.sr = 1'($urandom);
      if ($urandom_range(0, 99) < 10) return c;   // raw noise
      pick = $urandom_range(0, 99);
      if (pick < 22)      c.op = FN_UPDATE_WALLS;
      else if (pick < 42) c.op = FN_ADVANCE;
      else if (pick < 50) c.op = FN_TURN_LEFT;
      else if (pick < 58) c.op = FN_TURN_RIGHT;
      else if (pick < 66) c.op = FN_SET_POSE;
      else if (pick < 86) c.op = FN_QUERY_WALLS;
      else if (pick < 99) c.op = FN_QUERY_KNOWN;
      else                c.op = FN_CLEAR;
      c.cx = pick_coord(mouse_x);
      c.cy = pick_coord(mouse_y);
      return c;
   endfunction

   // ---------------------------------------------------------------- receiver and checker

   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < snk_idle_pct);
      end
   end

   task automatic compare_field(input string name, input int exp_val, input int act_val);
      if (exp_val !== act_val) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      maze_rsp_type e;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_answers.size() == 0) begin
            $error("response with no item outstanding");
            error_count++;
         end else begin
            e = expected_answers.pop_front();
            compare_field("wall_front",   e.wf, rsp_wall_front);
            compare_field("wall_left",    e.wl, rsp_wall_left);
            compare_field("wall_right",   e.wr, rsp_wall_right);
            compare_field("cell_known",   e.kn, rsp_cell_known);
            compare_field("moved",        e.mv, rsp_moved);
            compare_field("pose_x",       e.px, rsp_pose_x);
            compare_field("pose_y",       e.py, rsp_pose_y);
            compare_field("pose_heading", e.ph, rsp_pose_heading);
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_directed_cases();
      send_cmd(make_cmd(FN_QUERY_WALLS, 0, 0, HD_NORTH, 0, 0, 0));
      send_cmd(make_cmd(FN_QUERY_WALLS, 15, 15, HD_EAST, 0, 0, 0));
      send_cmd(make_cmd(FN_QUERY_WALLS, -32, 31, HD_WEST, 1, 1, 1));
      send_cmd(make_cmd(FN_QUERY_WALLS, 16, 0, HD_SOUTH, 0, 0, 0));
      send_cmd(make_cmd(FN_QUERY_KNOWN, 0, 0, HD_NORTH, 0, 0, 0));
      send_cmd(make_cmd(FN_UPDATE_WALLS, 0, 0, HD_NORTH, 1, 1, 1));
      send_cmd(make_cmd(FN_QUERY_KNOWN, 0, 0, HD_NORTH, 0, 0, 0));
      send_cmd(make_cmd(FN_QUERY_KNOWN, -1, 5, HD_NORTH, 0, 0, 0));
      // wall shared with the neighbour to the south
      send_cmd(make_cmd(FN_QUERY_WALLS, 0, 1, HD_SOUTH, 0, 0, 0));
      send_cmd(make_cmd(FN_TURN_LEFT, 0, 0, HD_NORTH, 0, 0, 0));
      send_cmd(make_cmd(FN_ADVANCE, 0, 0, HD_NORTH, 0, 0, 0));
      send_cmd(make_cmd(FN_TURN_RIGHT, 0, 0, HD_NORTH, 0, 0, 0));
      send_cmd(make_cmd(FN_TURN_RIGHT, 0, 0, HD_NORTH, 0, 0, 0));
      send_cmd(make_cmd(FN_ADVANCE, 0, 0, HD_NORTH, 0, 0, 0));
      send_cmd(make_cmd(FN_SET_POSE, 31, 5, HD_SOUTH, 0, 0, 0));
      send_cmd(make_cmd(FN_SET_POSE, 3, -32, HD_WEST, 0, 0, 0));
      send_cmd(make_cmd(FN_SET_POSE, -1, 16, HD_EAST, 0, 0, 0));
      send_cmd(make_cmd(FN_SET_POSE, 15, 15, HD_NORTH, 0, 0, 0));
      send_cmd(make_cmd(FN_ADVANCE, 0, 0, HD_NORTH, 0, 0, 0));
      send_cmd(make_cmd(FN_TURN_RIGHT, 0, 0, HD_NORTH, 0, 0, 0));
      send_cmd(make_cmd(FN_ADVANCE, 0, 0, HD_NORTH, 0, 0, 0));
      send_cmd(make_cmd(FN_SET_POSE, 0, 0, HD_SOUTH, 0, 0, 0));
      send_cmd(make_cmd(FN_ADVANCE, 0, 0, HD_NORTH, 0, 0, 0));
      send_cmd(make_cmd(FN_CLEAR, 0, 0, HD_NORTH, 0, 0, 0));
      send_cmd(make_cmd(FN_QUERY_WALLS, 0, 1, HD_SOUTH, 0, 0, 0));
   endtask

   task automatic test_random_traffic(input int count, input int src_pct, input int snk_pct);
      src_idle_pct = src_pct;
      snk_idle_pct = snk_pct;
      for (int i = 0; i < count; i++) send_cmd(random_cmd());
   endtask

   // hold the receiver so both pipeline registers fill and the input stalls
   task automatic test_receiver_holdoff();
      src_idle_pct = 0;
      snk_idle_pct = 0;
      hold_request = 60;
      for (int i = 0; i < 40; i++) send_cmd(random_cmd());
   endtask

   task automatic test_drain_pause();
      src_idle_pct = 0;
      snk_idle_pct = 30;
      for (int i = 0; i < 20; i++) send_cmd(random_cmd());
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_answers.size() != 0) @(posedge clock);
      for (int i = 0; i < 20; i++) send_cmd(random_cmd());
   endtask

   initial begin
      clear_maze();
      src_idle_pct = 21;
      snk_idle_pct = 50;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_traffic(320, 21, 50);
      test_random_traffic(320, 50, 21);
      test_receiver_holdoff();
      test_drain_pause();
      test_random_traffic(320, 0, 0);

      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
